### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the box merger RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define OBM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OBM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OBM_ASSERT(label, clk, rst_n, prop, msg)
`define OBM_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### sv/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg
// Box record and edge helpers for the overlapping box merger.
// ----------------------------------------------------------------------------
`default_nettype none

package obm_pkg;

	localparam int unsigned EdgeW = 13;  // left / top edge
	localparam int unsigned FarW  = 15;  // right / bottom edge, up to 8190

	// Boxes are held by their edges: right = left + width, bottom = top + height
	typedef struct packed {
		logic signed [EdgeW-1:0] left;
		logic signed [EdgeW-1:0] top;
		logic signed [FarW-1:0]  right;
		logic signed [FarW-1:0]  bottom;
	} box_t;

	function automatic logic signed [FarW-1:0] ext_edge(input logic signed [EdgeW-1:0] v);
		return {{(FarW-EdgeW){v[EdgeW-1]}}, v};
	endfunction

endpackage

`default_nettype wire

### sv/obm_merge_unit.sv
// ----------------------------------------------------------------------------
// obm_merge_unit
// Positive-area overlap test of two boxes and their bounding-box union.
// ----------------------------------------------------------------------------
`default_nettype none

module obm_merge_unit (
	input  obm_pkg::box_t a,
	input  obm_pkg::box_t b,
	output logic          hit,
	output obm_pkg::box_t united
);
	import obm_pkg::*;

	logic signed [FarW-1:0] al, bl, at, bt;
	logic signed [FarW-1:0] r_min, l_max, b_min, t_max;

	always_comb begin
		al = ext_edge(a.left);
		bl = ext_edge(b.left);
		at = ext_edge(a.top);
		bt = ext_edge(b.top);

		r_min = (a.right < b.right) ? a.right : b.right;
		l_max = (al > bl) ? al : bl;
		b_min = (a.bottom < b.bottom) ? a.bottom : b.bottom;
		t_max = (at > bt) ? at : bt;

		// both intersections must be strictly longer than zero
		hit = (r_min > l_max) && (b_min > t_max);

		united.left   = (a.left < b.left) ? a.left : b.left;
		united.top    = (a.top < b.top) ? a.top : b.top;
		united.right  = (a.right > b.right) ? a.right : b.right;
		united.bottom = (a.bottom > b.bottom) ? a.bottom : b.bottom;
	end

endmodule

`default_nettype wire

### sv/overlapping_box_merger_core.sv
// ----------------------------------------------------------------------------
// overlapping_box_merger_core
// Collects a list of boxes, merges overlapping ones in repeated passes and
// streams out the merged list.
//
//   channel  | signals                                  | beat
//   ---------+------------------------------------------+--------------------
//   box      | box_valid / box_ready, box_*, final_box  | one input box
//   merged   | merged_valid / merged_ready, merged_*,   | one merged box
//            | last_merged, dropped_input               |
//
// Loading accepts one box per cycle while idle. A merge pass seeds the
// merged list with the first source box, then compares each later source
// box with every merged entry so far, unioning on a hit and appending on a
// miss; a pass that merged anything copies the merged list back and runs
// again. Each result is registered and held until merged_ready.
// Boxes are taken only while no list is being merged or emitted.
// Reset clears the state, counters, flags and output registers; the list memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module overlapping_box_merger_core #(
	parameter int unsigned MAX_BOXES = 32
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               box_valid,
	output logic               box_ready,
	input  logic signed [12:0] box_x,
	input  logic signed [12:0] box_y,
	input  logic        [11:0] box_width,
	input  logic        [11:0] box_height,
	input  logic               final_box,

	output logic               merged_valid,
	input  logic               merged_ready,
	output logic signed [12:0] merged_x,
	output logic signed [12:0] merged_y,
	output logic        [12:0] merged_width,
	output logic        [12:0] merged_height,
	output logic               last_merged,
	output logic               dropped_input
);
	import obm_pkg::*;

	localparam int unsigned IW = $clog2(MAX_BOXES);
	localparam int unsigned CW = $clog2(MAX_BOXES + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT0,
		S_INIT1,
		S_SCAN,
		S_TAIL,
		S_PASS_END,
		S_COPY,
		S_COPY_TAIL,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   src_cnt_q, mrg_cnt_q;
	logic            ovf_q, chg_q, hit_q;
	logic [IW-1:0]   i_q, j_q;
	logic            rd_vld_s1;
	logic [IW-1:0]   rd_idx_s1;

	logic            merged_valid_q, last_merged_q, dropped_input_q;
	logic signed [12:0] merged_x_q, merged_y_q;
	logic [12:0]     merged_width_q, merged_height_q;

	box_t            src_mem [MAX_BOXES];
	box_t            mrg_mem [MAX_BOXES];
	box_t            src_rd_s1, mrg_rd_s1;

	logic [IW-1:0]   src_raddr, src_waddr, mrg_waddr;
	logic            src_we, mrg_we;
	box_t            src_wdata, mrg_wdata, in_box, united;
	logic            hit_now, box_fire, scan_last, copy_last, is_last;

	function automatic logic [12:0] sat_span(input logic signed [FarW-1:0] far_edge,
			input logic signed [EdgeW-1:0] near_edge);
		logic signed [FarW-1:0] span;
		span = far_edge - ext_edge(near_edge);
		return (span > 15'sd8191) ? 13'h1FFF : span[12:0];
	endfunction

	obm_merge_unit u_merge (
		.a      (mrg_rd_s1),
		.b      (src_rd_s1),
		.hit    (hit_now),
		.united (united)
	);

	always_comb begin
		box_fire  = box_valid && box_ready;
		scan_last = (CW'(j_q) + CW'(1)) == mrg_cnt_q;
		copy_last = scan_last;
		is_last   = scan_last;

		in_box.left   = box_x;
		in_box.top    = box_y;
		in_box.right  = ext_edge(box_x) + $signed({3'b000, box_width});
		in_box.bottom = ext_edge(box_y) + $signed({3'b000, box_height});

		src_raddr = (state_q == S_INIT0) ? '0 : i_q;

		// source list: loaded from the input, refreshed by the copy sweep
		src_we    = 1'b0;
		src_waddr = src_cnt_q[IW-1:0];
		src_wdata = in_box;
		if (state_q == S_IDLE && box_fire && src_cnt_q < CW'(MAX_BOXES)) begin
			src_we = 1'b1;
		end else if ((state_q == S_COPY || state_q == S_COPY_TAIL) && rd_vld_s1) begin
			src_we    = 1'b1;
			src_waddr = rd_idx_s1;
			src_wdata = mrg_rd_s1;
		end

		// merged list: seed entry, in-place union, or append after a miss
		mrg_we    = 1'b0;
		mrg_waddr = '0;
		mrg_wdata = src_rd_s1;
		if (state_q == S_INIT1) begin
			mrg_we = 1'b1;
		end else if ((state_q == S_SCAN || state_q == S_TAIL) && rd_vld_s1 && hit_now) begin
			mrg_we    = 1'b1;
			mrg_waddr = rd_idx_s1;
			mrg_wdata = united;
		end else if (state_q == S_TAIL && !hit_q) begin
			mrg_we    = 1'b1;
			mrg_waddr = mrg_cnt_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[src_waddr] <= src_wdata;
		end
		src_rd_s1 <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (mrg_we) begin
			mrg_mem[mrg_waddr] <= mrg_wdata;
		end
		mrg_rd_s1 <= mrg_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			src_cnt_q       <= '0;
			mrg_cnt_q       <= '0;
			ovf_q           <= 1'b0;
			chg_q           <= 1'b0;
			hit_q           <= 1'b0;
			i_q             <= '0;
			j_q             <= '0;
			rd_vld_s1       <= 1'b0;
			rd_idx_s1       <= '0;
			merged_valid_q  <= 1'b0;
			merged_x_q      <= '0;
			merged_y_q      <= '0;
			merged_width_q  <= '0;
			merged_height_q <= '0;
			last_merged_q   <= 1'b0;
			dropped_input_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) || (state_q == S_COPY);
			rd_idx_s1 <= j_q;

			if ((state_q == S_SCAN || state_q == S_TAIL) && rd_vld_s1 && hit_now) begin
				chg_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (box_fire) begin
						if (src_cnt_q < CW'(MAX_BOXES)) begin
							src_cnt_q <= src_cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_box) begin
							state_q <= S_INIT0;
						end
					end
				end
				S_INIT0: begin
					state_q <= S_INIT1;
				end
				S_INIT1: begin
					mrg_cnt_q <= CW'(1);
					chg_q     <= 1'b0;
					hit_q     <= 1'b0;
					i_q       <= IW'(1);
					j_q       <= '0;
					state_q   <= (src_cnt_q == CW'(1)) ? S_PASS_END : S_SCAN;
				end
				S_SCAN: begin
					if (rd_vld_s1 && hit_now) begin
						hit_q <= 1'b1;
					end
					j_q <= j_q + IW'(1);
					if (scan_last) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					// last union lands now; append if the box hit nothing
					if (!hit_q && !hit_now) begin
						mrg_cnt_q <= mrg_cnt_q + CW'(1);
					end
					hit_q <= 1'b0;
					j_q   <= '0;
					if ((CW'(i_q) + CW'(1)) == src_cnt_q) begin
						state_q <= S_PASS_END;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_SCAN;
					end
				end
				S_PASS_END: begin
					j_q <= '0;
					if (chg_q) begin
						src_cnt_q <= mrg_cnt_q;
						state_q   <= S_COPY;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_COPY: begin
					j_q <= j_q + IW'(1);
					if (copy_last) begin
						state_q <= S_COPY_TAIL;
					end
				end
				S_COPY_TAIL: begin
					state_q <= S_INIT0;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					merged_valid_q  <= 1'b1;
					merged_x_q      <= mrg_rd_s1.left;
					merged_y_q      <= mrg_rd_s1.top;
					merged_width_q  <= sat_span(mrg_rd_s1.right, mrg_rd_s1.left);
					merged_height_q <= sat_span(mrg_rd_s1.bottom, mrg_rd_s1.top);
					last_merged_q   <= is_last;
					dropped_input_q <= ovf_q;
					state_q         <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (merged_ready) begin
						merged_valid_q <= 1'b0;
						if (last_merged_q) begin
							// list done: clear the counts and flags for the next one
							src_cnt_q <= '0;
							mrg_cnt_q <= '0;
							ovf_q     <= 1'b0;
							chg_q     <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							j_q     <= j_q + IW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign box_ready     = (state_q == S_IDLE);
	assign merged_valid  = merged_valid_q;
	assign merged_x      = merged_x_q;
	assign merged_y      = merged_y_q;
	assign merged_width  = merged_width_q;
	assign merged_height = merged_height_q;
	assign last_merged   = last_merged_q;
	assign dropped_input = dropped_input_q;

	`OBM_ASSERT_NEVER(a_load_emit, clk, arst_n, box_ready && merged_valid, "load during emit")
	`OBM_ASSERT_NEVER(a_mrg_le_src, clk, arst_n, mrg_cnt_q > src_cnt_q, "merged > source")
	`OBM_ASSERT_NEVER(a_src_cap, clk, arst_n, src_cnt_q > CW'(MAX_BOXES), "count past cap")
	`OBM_ASSERT(a_reopen, clk, arst_n, merged_valid && merged_ready && last_merged |=> box_ready, "held")
	`OBM_ASSERT_NEVER(a_clean_emit, clk, arst_n, merged_valid && chg_q, "emit after merge")

endmodule

`default_nettype wire
